>>> rtl/core/cpd_pkg.sv
`timescale 1ns / 1ps

package cpd_pkg;

  localparam int unsigned ROWS_DEF = 256;
  localparam int unsigned COLS_DEF = 16;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned ROW_W    = 8;
  localparam int unsigned COL_W    = 4;
  localparam int unsigned DIST_W   = 26;
  localparam int unsigned RCFG_W   = 9;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    METRIC_EUCLID    = 2'd0,
    METRIC_MANHATTAN = 2'd1,
    METRIC_MAX       = 2'd2
  } metric_e;

  typedef enum logic [1:0] {
    STATUS_VALID   = 2'd0,
    STATUS_UNDEF   = 2'd1,
    STATUS_NO_ROWS = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_METRIC    = 2'd0,
    CFG_SKIP      = 2'd1,
    CFG_ROW_COUNT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] metric;
    logic       skip;
  } cpd_cfg_t;

  typedef struct packed {
    logic busy;
    logic undefined;
    logic counted;
  } cpd_acc_stat_t;

endpackage

>>> rtl/core/cpd_store.sv
`timescale 1ns / 1ps

module cpd_store #(
  parameter int unsigned DEPTH = cpd_pkg::ROWS_DEF * cpd_pkg::COLS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [cpd_pkg::SAMPLE_W:0]  wdata_i,
  input  logic [AW-1:0]               raddr_a_i,
  input  logic [AW-1:0]               raddr_b_i,
  output logic [cpd_pkg::SAMPLE_W:0]  rdata_a_o,
  output logic [cpd_pkg::SAMPLE_W:0]  rdata_b_o
);
  import cpd_pkg::*;

  logic [SAMPLE_W:0] mem_q [DEPTH];
  logic [SAMPLE_W:0] rdata_a_q;
  logic [SAMPLE_W:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> rtl/core/cpd_accum.sv
`timescale 1ns / 1ps

module cpd_accum #(
  parameter int unsigned ACC_W = 2 * cpd_pkg::SAMPLE_W + $clog2(cpd_pkg::ROWS_DEF + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  cpd_pkg::cpd_cfg_t           cfg_i,
  input  logic                        valid_i,
  input  logic                        oor_a_i,
  input  logic                        oor_b_i,
  input  logic [cpd_pkg::SAMPLE_W:0]  rdata_a_i,
  input  logic [cpd_pkg::SAMPLE_W:0]  rdata_b_i,
  output logic [ACC_W-1:0]            acc_o,
  output cpd_pkg::cpd_acc_stat_t      stat_o
);
  import cpd_pkg::*;

  logic [SAMPLE_W-1:0]   va;
  logic [SAMPLE_W-1:0]   vb;
  logic                  miss;
  logic [SAMPLE_W:0]     diff;
  logic [SAMPLE_W:0]     diff_abs;

  logic                  s1_valid_q;
  logic                  s1_miss_q;
  logic [SAMPLE_W-1:0]   s1_ad_q;
  logic                  s2_valid_q;
  logic                  s2_miss_q;
  logic [SAMPLE_W-1:0]   s2_ad_q;
  logic [2*SAMPLE_W-1:0] s2_sq_q;

  logic [ACC_W-1:0]      acc_q, acc_d;
  logic                  undef_q, undef_d;
  logic                  counted_q, counted_d;
  logic                  maxmode;

  assign maxmode = cfg_i.metric[1];

  always_comb begin
    va       = oor_a_i ? '0 : rdata_a_i[SAMPLE_W-1:0];
    vb       = oor_b_i ? '0 : rdata_b_i[SAMPLE_W-1:0];
    miss     = (!oor_a_i && rdata_a_i[SAMPLE_W]) || (!oor_b_i && rdata_b_i[SAMPLE_W]);
    diff     = {va[SAMPLE_W-1], va} - {vb[SAMPLE_W-1], vb};
    diff_abs = diff[SAMPLE_W] ? (~diff + (SAMPLE_W+1)'(1)) : diff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_miss_q <= miss;
    s1_ad_q   <= diff_abs[SAMPLE_W-1:0];
    s2_miss_q <= s1_miss_q;
    s2_ad_q   <= s1_ad_q;
    s2_sq_q   <= (2*SAMPLE_W)'(s1_ad_q) * (2*SAMPLE_W)'(s1_ad_q);
  end

  always_comb begin
    acc_d     = acc_q;
    undef_d   = undef_q;
    counted_d = counted_q;
    if (clear_i) begin
      acc_d     = '0;
      undef_d   = 1'b0;
      counted_d = 1'b0;
    end else if (s2_valid_q) begin
      if (s2_miss_q) begin
        if (!maxmode && !cfg_i.skip) begin
          undef_d = 1'b1;
        end
      end else begin
        counted_d = 1'b1;
        if (maxmode) begin
          if (ACC_W'(s2_ad_q) > acc_q) begin
            acc_d = ACC_W'(s2_ad_q);
          end
        end else if (cfg_i.metric == METRIC_EUCLID) begin
          acc_d = acc_q + ACC_W'(s2_sq_q);
        end else begin
          acc_d = acc_q + ACC_W'(s2_ad_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      undef_q   <= 1'b0;
      counted_q <= 1'b0;
    end else begin
      acc_q     <= acc_d;
      undef_q   <= undef_d;
      counted_q <= counted_d;
    end
  end

  assign acc_o            = acc_q;
  assign stat_o.busy      = s1_valid_q || s2_valid_q;
  assign stat_o.undefined = undef_q;
  assign stat_o.counted   = counted_q;

endmodule

>>> rtl/core/cpd_sqrt.sv
`timescale 1ns / 1ps

module cpd_sqrt #(
  parameter int unsigned ACC_W = 2 * cpd_pkg::SAMPLE_W + $clog2(cpd_pkg::ROWS_DEF + 1),
  parameter int unsigned ITER  = (ACC_W + 1) / 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ACC_W-1:0] x_i,
  output logic             done_o,
  output logic [ITER-1:0]  root_o
);
  import cpd_pkg::*;

  localparam int unsigned XW   = 2 * ITER;
  localparam int unsigned CNTW = $clog2(ITER + 1);

  logic [XW-1:0]   x_q;
  logic [XW-1:0]   res_q;
  logic [XW-1:0]   bit_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q;
  logic [XW-1:0]   trial;
  logic            ge;
  logic            step;

  assign trial = res_q + bit_q;
  assign ge    = x_q >= trial;
  assign step  = busy_q && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(ITER);
    end else if (step) begin
      cnt_q <= cnt_q - CNTW'(1);
    end else if (busy_q) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= XW'(x_i);
      res_q <= '0;
      bit_q <= XW'(1) << (XW - 2);
    end else if (step) begin
      if (ge) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign root_o = res_q[ITER-1:0];

endmodule

>>> rtl/core/column_pair_distance.sv
`timescale 1ns / 1ps
// channel | handshake              | payload
// --------+------------------------+------------------------------------------
// in      | in_valid_i / in_ready_o | op_i row_i col_a_i col_b_i value_i missing_i
// out     | out_valid_o/out_ready_i | distance_o status_o
// cfg     | cfg_we_i               | cfg_index_i cfg_data_i
//
// A load request writes the sample store at acceptance.
// A query request reads the first n rows (n = saturated row_count), one row pair
// per cycle from the store's two read ports, then runs the square root step
// unit for Euclidean unless the result is undefined.
// Reset clears control state only; the store holds no reset value.
// A finished result waits in the output register while the next request enters.

module column_pair_distance #(
  parameter int unsigned ROWS = cpd_pkg::ROWS_DEF,
  parameter int unsigned COLS = cpd_pkg::COLS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cpd_pkg::RCFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  logic [cpd_pkg::ROW_W-1:0]         row_i,
  input  logic [cpd_pkg::COL_W-1:0]         col_a_i,
  input  logic [cpd_pkg::COL_W-1:0]         col_b_i,
  input  logic signed [cpd_pkg::SAMPLE_W-1:0] value_i,
  input  logic                              missing_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cpd_pkg::DIST_W-1:0]        distance_o,
  output logic [1:0]                        status_o
);
  import cpd_pkg::*;

  localparam int unsigned DEPTH = ROWS * COLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CNT_W = $clog2(ROWS + 1);
  localparam int unsigned ACC_W = 2 * SAMPLE_W + CNT_W;
  localparam int unsigned ITER  = (ACC_W + 1) / 2;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RUN   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_ROOT  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  cpd_cfg_t         cfg_q;
  logic [RCFG_W-1:0] row_count_q;

  logic [COL_W-1:0] col_a_q, col_b_q;
  logic [CNT_W-1:0] rc_q, rc_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] n_sat;

  logic             accept;
  logic             load_ok;
  logic             issue;
  logic             rd_valid_q;
  logic             oor_a_q, oor_b_q;
  logic [AW-1:0]    waddr, raddr_a, raddr_b;
  logic [SAMPLE_W:0] rdata_a, rdata_b;

  logic [ACC_W-1:0] acc;
  cpd_acc_stat_t    acc_stat;
  logic             drained;
  logic             sqrt_start;
  logic             sqrt_done;
  logic [ITER-1:0]  root;

  logic             out_valid_q;
  logic [DIST_W-1:0] distance_q;
  logic [1:0]       status_q;
  logic             out_load;
  logic [63:0]      wide_dist;
  logic [DIST_W-1:0] dist_sat;
  logic [1:0]       status_res;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.metric <= METRIC_EUCLID;
      cfg_q.skip   <= 1'b1;
      row_count_q  <= RCFG_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_METRIC:    cfg_q.metric <= cfg_data_i[1:0];
        CFG_SKIP:      cfg_q.skip   <= cfg_data_i[0];
        CFG_ROW_COUNT: row_count_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load_ok    = (32'(row_i) < ROWS) && (32'(col_a_i) < COLS);
  assign n_sat      = (32'(row_count_q) > ROWS) ? CNT_W'(ROWS) : CNT_W'(row_count_q);
  assign issue      = (state_q == S_RUN);
  assign drained    = !rd_valid_q && !acc_stat.busy;

  assign waddr   = AW'(32'(col_a_i) * ROWS + 32'(row_i));
  assign raddr_a = AW'(32'(col_a_q) * ROWS + 32'(rc_q[RW-1:0]));
  assign raddr_b = AW'(32'(col_b_q) * ROWS + 32'(rc_q[RW-1:0]));

  assign sqrt_start = (state_q == S_DRAIN) && drained &&
                      (cfg_q.metric == METRIC_EUCLID) && !acc_stat.undefined;

  always_comb begin
    state_d = state_q;
    rc_d    = rc_q;
    n_d     = n_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (op_i == OP_QUERY)) begin
          rc_d    = '0;
          n_d     = n_sat;
          state_d = (n_sat == '0) ? S_DRAIN : S_RUN;
        end
      end
      S_RUN: begin
        rc_d = rc_q + CNT_W'(1);
        if ((rc_q + CNT_W'(1)) == n_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drained) begin
          state_d = sqrt_start ? S_ROOT : S_DONE;
        end
      end
      S_ROOT: begin
        if (sqrt_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rc_q       <= '0;
      n_q        <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rc_q       <= rc_d;
      n_q        <= n_d;
      rd_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_a_q <= col_a_i;
      col_b_q <= col_b_i;
    end
    oor_a_q <= 32'(col_a_q) >= COLS;
    oor_b_q <= 32'(col_b_q) >= COLS;
  end

  cpd_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (accept && (op_i == OP_LOAD) && load_ok),
    .waddr_i   (waddr),
    .wdata_i   ({missing_i, value_i}),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  cpd_accum #(
    .ACC_W (ACC_W)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (accept && (op_i == OP_QUERY)),
    .cfg_i     (cfg_q),
    .valid_i   (rd_valid_q),
    .oor_a_i   (oor_a_q),
    .oor_b_i   (oor_b_q),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .acc_o     (acc),
    .stat_o    (acc_stat)
  );

  cpd_sqrt #(
    .ACC_W (ACC_W),
    .ITER  (ITER)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (acc),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // result select and saturate
  always_comb begin
    wide_dist  = '0;
    status_res = STATUS_VALID;
    if (cfg_q.metric[1]) begin
      if (acc_stat.counted) begin
        wide_dist = 64'(acc);
      end else begin
        status_res = STATUS_NO_ROWS;
      end
    end else if (acc_stat.undefined) begin
      status_res = STATUS_UNDEF;
    end else if (cfg_q.metric == METRIC_EUCLID) begin
      wide_dist = 64'(root);
    end else begin
      wide_dist = 64'(acc);
    end
    dist_sat = (wide_dist > 64'(DIST_MAX)) ? DIST_MAX : wide_dist[DIST_W-1:0];
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      distance_q <= dist_sat;
      status_q   <= status_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = distance_q;
  assign status_o    = status_q;

endmodule

>>> tb/column_pair_distance_checker.sv
`timescale 1ns / 1ps

module column_pair_distance_checker #(
  parameter int unsigned ROWS = cpd_pkg::ROWS_DEF,
  parameter int unsigned COLS = cpd_pkg::COLS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cpd_pkg::RCFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic                              op_i,
  input  logic [cpd_pkg::ROW_W-1:0]         row_i,
  input  logic [cpd_pkg::COL_W-1:0]         col_a_i,
  input  logic [cpd_pkg::COL_W-1:0]         col_b_i,
  input  logic [cpd_pkg::SAMPLE_W-1:0]      value_i,
  input  logic                              missing_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [cpd_pkg::DIST_W-1:0]        distance_i,
  input  logic [1:0]                        status_i,
  output int                                fail_count_o,
  output int                                open_queries_o
);
  import cpd_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    status_e           status;
  } dist_result_t;

  logic [SAMPLE_W-1:0] sample_mem [ROWS*COLS];
  logic                miss_mem   [ROWS*COLS];
  logic [1:0]          metric_q;
  logic                skip_q;
  logic [RCFG_W-1:0]   rows_q;
  dist_result_t        expected_q [$];
  dist_result_t        want;
  int                  fails = 0;
  int                  open_cnt = 0;

  assign fail_count_o   = fails;
  assign open_queries_o = open_cnt;

  function automatic logic [31:0] floor_sqrt(logic [63:0] x);
    logic [31:0] res;
    logic [31:0] trial;
    logic [63:0] sq;
    res = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = res | (32'd1 << b);
      sq    = 64'(trial) * 64'(trial);
      if (sq <= x) res = trial;
    end
    return res;
  endfunction

  function automatic dist_result_t predict_distance(logic [COL_W-1:0] ca, logic [COL_W-1:0] cb);
    dist_result_t res;
    int unsigned  n;
    int unsigned  hits;
    int unsigned  ia;
    int unsigned  ib;
    int           va;
    int           vb;
    int           diff;
    logic [63:0]  acc;
    logic [63:0]  mag;
    logic [63:0]  total;
    bit           undef;
    bit           max_mode;
    n        = (rows_q > ROWS) ? ROWS : rows_q;
    max_mode = metric_q[1];
    hits     = 0;
    acc      = '0;
    undef    = 1'b0;
    for (int unsigned r = 0; r < n; r++) begin
      ia = int'(ca) * ROWS + r;
      ib = int'(cb) * ROWS + r;
      if (miss_mem[ia] || miss_mem[ib]) begin
        if (!max_mode && !skip_q) undef = 1'b1;
        continue;
      end
      va   = int'($signed(sample_mem[ia]));
      vb   = int'($signed(sample_mem[ib]));
      diff = va - vb;
      mag  = 64'((diff < 0) ? -diff : diff);
      hits++;
      if (max_mode) begin
        if (mag > acc) acc = mag;
      end else if (metric_q == METRIC_EUCLID) begin
        acc += mag * mag;
      end else begin
        acc += mag;
      end
    end
    total      = '0;
    res.status = STATUS_VALID;
    if (max_mode) begin
      if (hits == 0) res.status = STATUS_NO_ROWS;
      else total = acc;
    end else if (undef) begin
      res.status = STATUS_UNDEF;
    end else if (metric_q == METRIC_EUCLID) begin
      total = 64'(floor_sqrt(acc));
    end else begin
      total = acc;
    end
    if (total > 64'(DIST_MAX)) total = 64'(DIST_MAX);
    res.distance = total[DIST_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= METRIC_EUCLID;
      skip_q   <= 1'b1;
      rows_q   <= RCFG_W'(256);
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_METRIC:    metric_q <= cfg_data_i[1:0];
          CFG_SKIP:      skip_q   <= cfg_data_i[0];
          CFG_ROW_COUNT: rows_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (op_e'(op_i) == OP_LOAD) begin
          sample_mem[int'(col_a_i) * ROWS + int'(row_i)] <= value_i;
          miss_mem[int'(col_a_i) * ROWS + int'(row_i)]   <= missing_i;
        end else begin
          expected_q.push_back(predict_distance(col_a_i, col_b_i));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: distance %0d status %0d", distance_i, status_i);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (distance_i !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, distance_i);
            fails++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fails++;
          end
        end
      end
      open_cnt <= expected_q.size();
    end
  end

endmodule

>>> tb/column_pair_distance_test.sv
`timescale 1ns / 1ps

module column_pair_distance_test;
  import cpd_pkg::*;

  localparam int unsigned ROWS          = ROWS_DEF;
  localparam int unsigned COLS          = COLS_DEF;
  localparam int unsigned SETTLE_CYCLES = ROWS + 64;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASES        = 15;
  localparam logic [1:0]  METRIC_ALIAS  = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_METRIC;
  logic [RCFG_W-1:0]   cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                op_i        = OP_LOAD;
  logic [ROW_W-1:0]    row_i       = '0;
  logic [COL_W-1:0]    col_a_i     = '0;
  logic [COL_W-1:0]    col_b_i     = '0;
  logic [SAMPLE_W-1:0] value_i     = '0;
  logic                missing_i   = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [DIST_W-1:0]   distance_o;
  logic [1:0]          status_o;

  int                  fail_count;
  int                  open_queries;
  bit                  written [COLS][ROWS];
  int unsigned         tx_idle_pct  = 0;
  int unsigned         rx_stall_pct = 0;
  int unsigned         hold_left    = 0;
  bit                  hold_toggle  = 1'b0;
  bit                  hold_seen    = 1'b0;

  always #5 clk_i = ~clk_i;

  column_pair_distance #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .row_i      (row_i),
    .col_a_i    (col_a_i),
    .col_b_i    (col_b_i),
    .value_i    (value_i),
    .missing_i  (missing_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .distance_o (distance_o),
    .status_o   (status_o)
  );

  column_pair_distance_checker #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .op_i          (op_i),
    .row_i         (row_i),
    .col_a_i       (col_a_i),
    .col_b_i       (col_b_i),
    .value_i       (value_i),
    .missing_i     (missing_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .distance_i    (distance_o),
    .status_i      (status_o),
    .fail_count_o  (fail_count),
    .open_queries_o(open_queries)
  );

  // hold off the result side for a long stretch on request
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen   <= hold_toggle;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(511)) - 16'd256;
      3: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int unsigned filled_rows(int unsigned c, int unsigned m);
    int unsigned cnt;
    cnt = 0;
    for (int unsigned r = 0; r < m; r++) if (written[c][r]) cnt++;
    return cnt;
  endfunction

  task automatic send_request(op_e op, logic [ROW_W-1:0] row, logic [COL_W-1:0] ca,
                              logic [COL_W-1:0] cb, logic [SAMPLE_W-1:0] v, logic miss);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    row_i      <= row;
    col_a_i    <= ca;
    col_b_i    <= cb;
    value_i    <= v;
    missing_i  <= miss;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_LOAD) written[ca][row] = 1'b1;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (open_queries != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(logic [1:0] metric, logic skip, logic [RCFG_W-1:0] rows);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_METRIC;
    cfg_data_i  <= RCFG_W'(metric);
    @(posedge clk_i);
    cfg_index_i <= CFG_SKIP;
    cfg_data_i  <= RCFG_W'(skip);
    @(posedge clk_i);
    cfg_index_i <= CFG_ROW_COUNT;
    cfg_data_i  <= rows;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_item(int unsigned m);
    int unsigned ready_cols [$];
    int unsigned pick;
    int unsigned c;
    int unsigned r;
    int unsigned start;
    int unsigned cnt;
    int          best_cnt;
    for (int unsigned i = 0; i < COLS; i++) if (filled_rows(i, m) == m) ready_cols.push_back(i);
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_request(OP_LOAD, ROW_W'($urandom_range(ROWS - 1)), COL_W'($urandom_range(COLS - 1)),
                   COL_W'($urandom), random_sample(), $urandom_range(3) == 0);
    end else if (ready_cols.size() != 0 && pick < 55) begin
      send_request(OP_QUERY, ROW_W'($urandom),
                   COL_W'(ready_cols[$urandom_range(ready_cols.size() - 1)]),
                   COL_W'(ready_cols[$urandom_range(ready_cols.size() - 1)]),
                   SAMPLE_W'($urandom), 1'($urandom));
    end else if (ready_cols.size() != 0 && (pick < 70 || ready_cols.size() == COLS)) begin
      c = ready_cols[$urandom_range(ready_cols.size() - 1)];
      r = (m > 0) ? $urandom_range(m - 1) : $urandom_range(ROWS - 1);
      send_request(OP_LOAD, ROW_W'(r), COL_W'(c), COL_W'($urandom), random_sample(),
                   $urandom_range(99) < 4);
    end else begin
      // finish the most complete column first
      best_cnt = -1;
      c        = 0;
      start    = $urandom_range(COLS - 1);
      for (int unsigned i = 0; i < COLS; i++) begin
        cnt = filled_rows((start + i) % COLS, m);
        if (cnt != m && int'(cnt) > best_cnt) begin
          best_cnt = cnt;
          c        = (start + i) % COLS;
        end
      end
      r = 0;
      while (written[c][r]) r++;
      send_request(OP_LOAD, ROW_W'(r), COL_W'(c), COL_W'($urandom), random_sample(),
                   $urandom_range(99) < 4);
    end
  endtask

  initial begin
    int unsigned rows_tab  [PHASES] = '{1, 4, 9, 16, 0, 2, 12, 33, 5, 64, 7, 3, 256, 511, 300};
    int unsigned items_tab [PHASES] = '{30, 30, 30, 30, 20, 30, 30, 40, 30, 120, 30, 30, 600,
                                        60, 40};
    int unsigned m;
    int unsigned guard;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_config(METRIC_EUCLID, 1'b0, RCFG_W'(2));
    send_request(OP_LOAD, 8'd0, 4'd0, 4'd9, 16'h7FFF, 1'b0);
    send_request(OP_LOAD, 8'd1, 4'd0, 4'd9, 16'h8000, 1'b0);
    send_request(OP_LOAD, 8'd0, 4'd1, 4'd0, 16'h8000, 1'b0);
    send_request(OP_LOAD, 8'd1, 4'd1, 4'd0, 16'h7FFF, 1'b0);
    send_request(OP_LOAD, 8'd0, 4'd2, 4'd0, 16'h0100, 1'b1);
    send_request(OP_LOAD, 8'd1, 4'd2, 4'd0, 16'h0180, 1'b0);
    send_request(OP_LOAD, 8'd0, 4'd15, 4'd15, 16'h0001, 1'b1);
    send_request(OP_LOAD, 8'd1, 4'd15, 4'd15, 16'h0002, 1'b1);
    send_request(OP_LOAD, 8'd255, 4'd15, 4'd15, 16'hFFFF, 1'b0);
    send_request(OP_QUERY, 8'd0, 4'd0, 4'd1, '0, 1'b0);
    send_request(OP_QUERY, 8'd0, 4'd0, 4'd2, '0, 1'b0);
    send_request(OP_QUERY, 8'd0, 4'd1, 4'd1, '0, 1'b0);
    settle();
    write_config(METRIC_MANHATTAN, 1'b0, RCFG_W'(2));
    send_request(OP_QUERY, 8'd0, 4'd1, 4'd0, '0, 1'b0);
    send_request(OP_QUERY, 8'd0, 4'd2, 4'd0, '0, 1'b0);
    settle();
    write_config(METRIC_MANHATTAN, 1'b1, RCFG_W'(2));
    send_request(OP_QUERY, 8'd0, 4'd2, 4'd0, '0, 1'b0);
    send_request(OP_QUERY, 8'd0, 4'd15, 4'd2, '0, 1'b0);
    settle();
    write_config(METRIC_EUCLID, 1'b1, RCFG_W'(2));
    send_request(OP_QUERY, 8'd0, 4'd15, 4'd0, '0, 1'b0);
    settle();
    write_config(METRIC_MAX, 1'b0, RCFG_W'(2));
    send_request(OP_QUERY, 8'd0, 4'd0, 4'd1, '0, 1'b0);
    send_request(OP_QUERY, 8'd0, 4'd15, 4'd1, '0, 1'b0);
    settle();
    write_config(METRIC_ALIAS, 1'b1, RCFG_W'(2));
    send_request(OP_QUERY, 8'd0, 4'd1, 4'd0, '0, 1'b0);
    settle();
    write_config(METRIC_MAX, 1'b1, RCFG_W'(0));
    send_request(OP_QUERY, 8'd0, 4'd0, 4'd1, '0, 1'b0);
    settle();
    write_config(METRIC_EUCLID, 1'b0, RCFG_W'(0));
    send_request(OP_QUERY, 8'd0, 4'd2, 4'd15, '0, 1'b0);
    settle();
    write_config(METRIC_MANHATTAN, 1'b0, RCFG_W'(1));
    send_request(OP_QUERY, 8'd0, 4'd0, 4'd2, '0, 1'b0);

    for (int unsigned k = 0; k < PHASES; k++) begin
      settle();
      write_config(2'($urandom_range(3)), 1'($urandom_range(1)), RCFG_W'(rows_tab[k]));
      case (k % 4)
        0: begin
          tx_idle_pct   = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct   = 71;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct   = 0;
          rx_stall_pct <= 71;
        end
        default: begin
          tx_idle_pct   = 31;
          rx_stall_pct <= 31;
        end
      endcase
      if (k == 0) hold_toggle <= ~hold_toggle;
      m = (rows_tab[k] > ROWS) ? ROWS : rows_tab[k];
      repeat (items_tab[k]) random_item(m);
    end

    in_valid_i <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (open_queries != 0 && guard < 200000);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && open_queries == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> column_pair_distance.f
rtl/core/cpd_pkg.sv
rtl/core/cpd_store.sv
rtl/core/cpd_accum.sv
rtl/core/cpd_sqrt.sv
rtl/core/column_pair_distance.sv
tb/column_pair_distance_checker.sv
tb/column_pair_distance_test.sv
